/* src/retransmit_window_tracker_macros.svh */
// Assertion macros used by the retransmit window tracker RTL.
`ifndef RETRANSMIT_WINDOW_TRACKER_MACROS_SVH
`define RETRANSMIT_WINDOW_TRACKER_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define RWT_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rwt check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define RWT_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rwt check failed");

`endif

/* src/rwt_pkg.sv */
// Shared types and constants of the retransmit window tracker.
package rwt_pkg;

    localparam int PENDING_DEPTH_DEF = 1024;
    localparam int ACK_WIDTH_DEF     = 8;
    localparam int ACK_FIELDS        = 8;
    localparam int SEQ_W             = 32;
    localparam int SENT_W            = 6;
    localparam int RBUF_DEPTH        = 64;
    localparam int CNT_W             = 11;
    localparam int S_TDATA_W         = 288;
    localparam int M_TDATA_W         = 48;

    localparam logic [1:0] OP_TICK  = 2'd0;
    localparam logic [1:0] OP_ACK   = 2'd1;
    localparam logic [1:0] OP_START = 2'd2;

    localparam logic [1:0] CFG_CHUNK_COUNT    = 2'd0;
    localparam logic [1:0] CFG_RESEND_TIMEOUT = 2'd1;
    localparam logic [1:0] CFG_SEND_BUDGET    = 2'd2;

    localparam logic [31:0] CHUNK_COUNT_RST    = 32'd0;
    localparam logic [15:0] RESEND_TIMEOUT_RST = 16'd1000;
    localparam logic [5:0]  SEND_BUDGET_RST    = 6'd16;

    // One pending table entry as it moves down the ack cell chain.
    typedef struct packed {
        logic             valid;
        logic [SEQ_W-1:0] seq;
        logic [SEQ_W-1:0] stamp;
    } entry_t;

endpackage

/* src/rwt_ack_cell.sv */
// One cell of the ack chain: holds one acknowledged sequence and removes its first match.
module rwt_ack_cell (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          load,
    input  logic [rwt_pkg::SEQ_W-1:0]     load_seq,
    input  rwt_pkg::entry_t               entry_in,
    output rwt_pkg::entry_t               entry_out
);
    import rwt_pkg::*;

    logic [SEQ_W-1:0] ack_reg;
    logic             used_reg;
    logic             used_next;
    logic             hit;
    logic             out_valid_reg;
    logic [SEQ_W-1:0] out_seq_reg;
    logic [SEQ_W-1:0] out_stamp_reg;
    logic             out_valid_next;

    // The cell consumes the first entry that matches while its ack is unused.
    assign hit            = entry_in.valid && !used_reg && (entry_in.seq == ack_reg);
    assign used_next      = load ? 1'b0 : (used_reg || hit);
    assign out_valid_next = entry_in.valid && !hit;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            used_reg      <= 1'b1;
            out_valid_reg <= 1'b0;
        end else begin
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            ack_reg <= load_seq;
        end
        out_seq_reg   <= entry_in.seq;
        out_stamp_reg <= entry_in.stamp;
    end

    assign entry_out = {out_valid_reg, out_seq_reg, out_stamp_reg};

endmodule

/* src/retransmit_window_tracker.sv */
// Top level of the retransmit window tracker: pending table, scan sequencer and ack chain.
// Tick: one table entry a cycle is scanned until the table ends or the budget is spent, then
// new sends are written, then each result item is fetched and put out, waiting on stalls.
// Ack: the table runs through the ack cell chain, survivors are packed, then the result item
// is put out. Start and unused codes go straight to putting out their result item. One item
// is worked at a time. Reset is synchronous, active low; table contents are never cleared.
module retransmit_window_tracker #(
    parameter int PENDING_DEPTH = rwt_pkg::PENDING_DEPTH_DEF,
    parameter int ACK_WIDTH     = rwt_pkg::ACK_WIDTH_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // now, ack_seq_0 .. ack_seq_7
    input  logic [rwt_pkg::S_TDATA_W-1:0]   s_tdata,
    // opcode
    input  logic [1:0]                      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // send_seq, transfer_done, pending_count, zero padding
    output logic [rwt_pkg::M_TDATA_W-1:0]   m_tdata,
    // send_valid, is_resend
    output logic [1:0]                      m_tuser,
    output logic                            m_tlast,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [1:0]                      cfg_index,
    input  logic [31:0]                     cfg_data
);
    import rwt_pkg::*;

    `include "retransmit_window_tracker_macros.svh"

    localparam int IDX_W   = $clog2(PENDING_DEPTH);
    localparam int SIZE_W  = $clog2(PENDING_DEPTH + 1);
    localparam int N_CELLS = (ACK_WIDTH < ACK_FIELDS) ? ACK_WIDTH : ACK_FIELDS;
    localparam int DRAIN   = N_CELLS + 1;
    localparam int DRAIN_W = $clog2(N_CELLS + 2);
    localparam int RBUF_W  = $clog2(RBUF_DEPTH);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_SCAN  = 6'b000010,
        S_NEW   = 6'b000100,
        S_ACK   = 6'b001000,
        S_FETCH = 6'b010000,
        S_PUT   = 6'b100000
    } state_t;

    state_t              state_reg, state_next;
    logic [31:0]         chunk_reg;
    logic [15:0]         timeout_reg;
    logic [5:0]          budget_reg;
    logic [SEQ_W-1:0]    next_seq_reg, next_seq_next;
    logic [SIZE_W-1:0]   size_reg, size_next;
    logic [SENT_W-1:0]   sent_reg, sent_next;
    logic [SIZE_W-1:0]   rd_idx_reg, rd_idx_next;
    logic                pv_reg, pv_next;
    logic [SIZE_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [DRAIN_W-1:0]  drain_reg, drain_next;
    logic [SENT_W-1:0]   emit_reg, emit_next;
    logic                m_valid_reg, m_valid_next;

    // Payload registers.
    logic [SEQ_W-1:0]    now_reg, now_next;
    logic                only_reg, only_next;
    logic [IDX_W-1:0]    pidx_reg, pidx_next;
    logic [SEQ_W-1:0]    out_seq_reg, out_seq_next;
    logic                out_kind_reg, out_kind_next;
    logic                out_sv_reg, out_sv_next;
    logic                out_done_reg, out_done_next;
    logic [CNT_W-1:0]    out_cnt_reg, out_cnt_next;
    logic                out_last_reg, out_last_next;

    // Pending table: seq in the upper half, stamp in the lower half.
    logic [2*SEQ_W-1:0]  table_mem [PENDING_DEPTH];
    logic [2*SEQ_W-1:0]  rdata_reg;
    logic                rd_en, wr_en;
    logic [IDX_W-1:0]    rd_addr, wr_addr;
    logic [2*SEQ_W-1:0]  wr_data;

    // Result buffer: kind above seq.
    logic [SEQ_W:0]      rbuf_mem [RBUF_DEPTH];
    logic [SEQ_W:0]      rbuf_q_reg;
    logic                buf_we, buf_re;
    logic [SEQ_W:0]      buf_wdata;

    logic                cells_load;
    entry_t              chain [N_CELLS+1];

    logic [SEQ_W-1:0]    age;
    logic                resend_hit;
    logic                put_last;
    logic                done_now;
    logic [31:0]         size_wide;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_valid_reg;
    assign m_tdata   = {4'b0000, out_cnt_reg, out_done_reg, out_seq_reg};
    assign m_tuser   = {out_kind_reg, out_sv_reg};
    assign m_tlast   = out_last_reg;

    // The chain is fed from the table read register while an ack walks the table.
    assign chain[0] = {pv_reg && (state_reg == S_ACK), rdata_reg};

    genvar k;
    generate
        for (k = 0; k < N_CELLS; k++) begin : g_cell
            rwt_ack_cell u_cell (
                .aclk      (aclk),
                .aresetn   (aresetn),
                .load      (cells_load),
                .load_seq  (s_tdata[SEQ_W*k+SEQ_W +: SEQ_W]),
                .entry_in  (chain[k]),
                .entry_out (chain[k+1])
            );
        end
    endgenerate

    assign age        = now_reg - rdata_reg[SEQ_W-1:0];
    assign resend_hit = pv_reg && (sent_reg < budget_reg) &&
                        (only_reg || (age > 32'(timeout_reg)));
    assign done_now   = (next_seq_reg >= chunk_reg) && (size_reg == '0);
    assign size_wide  = 32'(size_reg);
    assign put_last   = (sent_reg == '0) || (emit_reg == (sent_reg - SENT_W'(1)));

    always_comb begin
        state_next    = state_reg;
        next_seq_next = next_seq_reg;
        size_next     = size_reg;
        sent_next     = sent_reg;
        rd_idx_next   = rd_idx_reg;
        pv_next       = pv_reg;
        wr_ptr_next   = wr_ptr_reg;
        drain_next    = drain_reg;
        emit_next     = emit_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        now_next      = now_reg;
        only_next     = only_reg;
        pidx_next     = pidx_reg;
        out_seq_next  = out_seq_reg;
        out_kind_next = out_kind_reg;
        out_sv_next   = out_sv_reg;
        out_done_next = out_done_reg;
        out_cnt_next  = out_cnt_reg;
        out_last_next = out_last_reg;
        rd_en         = 1'b0;
        rd_addr       = rd_idx_reg[IDX_W-1:0];
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = '0;
        buf_we        = 1'b0;
        buf_re        = 1'b0;
        buf_wdata     = '0;
        cells_load    = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_tvalid) begin
                    now_next    = s_tdata[SEQ_W-1:0];
                    sent_next   = '0;
                    rd_idx_next = '0;
                    pv_next     = 1'b0;
                    wr_ptr_next = '0;
                    drain_next  = '0;
                    emit_next   = '0;
                    case (s_tuser)
                        OP_TICK: begin
                            only_next  = (next_seq_reg >= chunk_reg);
                            state_next = S_SCAN;
                        end
                        OP_ACK: begin
                            cells_load = 1'b1;
                            state_next = S_ACK;
                        end
                        OP_START: begin
                            size_next     = '0;
                            next_seq_next = '0;
                            state_next    = S_PUT;
                        end
                        default: begin
                            state_next = S_PUT;
                        end
                    endcase
                end
            end
            S_SCAN: begin
                // The entry read last cycle is judged while the next one is fetched.
                if (resend_hit) begin
                    wr_en     = 1'b1;
                    wr_addr   = pidx_reg;
                    wr_data   = {rdata_reg[2*SEQ_W-1:SEQ_W], now_reg};
                    buf_we    = 1'b1;
                    buf_wdata = {1'b1, rdata_reg[2*SEQ_W-1:SEQ_W]};
                    sent_next = sent_reg + SENT_W'(1);
                end
                if ((sent_next == budget_reg) || ((rd_idx_reg == size_reg) && !pv_reg)) begin
                    pv_next    = 1'b0;
                    state_next = S_NEW;
                end else if (rd_idx_reg < size_reg) begin
                    rd_en       = 1'b1;
                    pv_next     = 1'b1;
                    pidx_next   = rd_idx_reg[IDX_W-1:0];
                    rd_idx_next = rd_idx_reg + SIZE_W'(1);
                end else begin
                    pv_next = 1'b0;
                end
            end
            S_NEW: begin
                if ((sent_reg < budget_reg) && (next_seq_reg < chunk_reg) &&
                    (size_reg < SIZE_W'(PENDING_DEPTH))) begin
                    wr_en         = 1'b1;
                    wr_addr       = size_reg[IDX_W-1:0];
                    wr_data       = {next_seq_reg, now_reg};
                    buf_we        = 1'b1;
                    buf_wdata     = {1'b0, next_seq_reg};
                    sent_next     = sent_reg + SENT_W'(1);
                    size_next     = size_reg + SIZE_W'(1);
                    next_seq_next = next_seq_reg + SEQ_W'(1);
                end else begin
                    state_next = S_FETCH;
                end
            end
            S_ACK: begin
                // Survivors leave the chain in order and are packed toward the front.
                if (chain[N_CELLS].valid) begin
                    wr_en       = 1'b1;
                    wr_addr     = wr_ptr_reg[IDX_W-1:0];
                    wr_data     = {chain[N_CELLS].seq, chain[N_CELLS].stamp};
                    wr_ptr_next = wr_ptr_reg + SIZE_W'(1);
                end
                if (rd_idx_reg < size_reg) begin
                    rd_en       = 1'b1;
                    pv_next     = 1'b1;
                    rd_idx_next = rd_idx_reg + SIZE_W'(1);
                end else begin
                    pv_next    = 1'b0;
                    drain_next = drain_reg + DRAIN_W'(1);
                    if (drain_reg == DRAIN_W'(DRAIN)) begin
                        size_next  = wr_ptr_reg;
                        state_next = S_PUT;
                    end
                end
            end
            S_FETCH: begin
                buf_re     = 1'b1;
                state_next = S_PUT;
            end
            S_PUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next  = 1'b1;
                    out_sv_next   = (sent_reg != '0);
                    out_seq_next  = (sent_reg != '0) ? rbuf_q_reg[SEQ_W-1:0] : '0;
                    out_kind_next = (sent_reg != '0) ? rbuf_q_reg[SEQ_W] : 1'b0;
                    out_done_next = done_now;
                    out_cnt_next  = size_wide[CNT_W-1:0];
                    out_last_next = put_last;
                    emit_next     = emit_reg + SENT_W'(1);
                    state_next    = put_last ? S_IDLE : S_FETCH;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            next_seq_reg <= '0;
            size_reg     <= '0;
            sent_reg     <= '0;
            rd_idx_reg   <= '0;
            pv_reg       <= 1'b0;
            wr_ptr_reg   <= '0;
            drain_reg    <= '0;
            emit_reg     <= '0;
            m_valid_reg  <= 1'b0;
        end else begin
            state_reg    <= state_next;
            next_seq_reg <= next_seq_next;
            size_reg     <= size_next;
            sent_reg     <= sent_next;
            rd_idx_reg   <= rd_idx_next;
            pv_reg       <= pv_next;
            wr_ptr_reg   <= wr_ptr_next;
            drain_reg    <= drain_next;
            emit_reg     <= emit_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        now_reg      <= now_next;
        only_reg     <= only_next;
        pidx_reg     <= pidx_next;
        out_seq_reg  <= out_seq_next;
        out_kind_reg <= out_kind_next;
        out_sv_reg   <= out_sv_next;
        out_done_reg <= out_done_next;
        out_cnt_reg  <= out_cnt_next;
        out_last_reg <= out_last_next;
    end

    // Configuration registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_reg   <= CHUNK_COUNT_RST;
            timeout_reg <= RESEND_TIMEOUT_RST;
            budget_reg  <= SEND_BUDGET_RST;
        end else if (cfg_valid) begin
            case (cfg_index)
                CFG_CHUNK_COUNT:    chunk_reg   <= cfg_data;
                CFG_RESEND_TIMEOUT: timeout_reg <= cfg_data[15:0];
                CFG_SEND_BUDGET:    budget_reg  <= cfg_data[5:0];
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rdata_reg <= table_mem[rd_addr];
        end
        if (wr_en) begin
            table_mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (buf_we) begin
            rbuf_mem[sent_reg[RBUF_W-1:0]] <= buf_wdata;
        end
        if (buf_re) begin
            rbuf_q_reg <= rbuf_mem[emit_reg[RBUF_W-1:0]];
        end
    end

    // The table never holds more entries than it has rows.
    `RWT_ASSERT_IMP(a_size_bound, aclk, aresetn, 1'b1, size_reg <= SIZE_W'(PENDING_DEPTH))
    // Compaction never writes ahead of the entries still to be read.
    `RWT_ASSERT_IMP(a_ack_pack, aclk, aresetn, state_reg == S_ACK, wr_ptr_reg <= rd_idx_reg)
    // A tick never issues more sends than its budget.
    `RWT_ASSERT_IMP(a_budget, aclk, aresetn, (state_reg == S_SCAN) || (state_reg == S_NEW), sent_reg <= budget_reg)
    // Once a result is offered it stays offered until taken.
    `RWT_ASSERT_NXT(a_out_hold, aclk, aresetn, m_valid_reg && !m_tready, m_valid_reg)

endmodule

/* bench/tb_retransmit_window_tracker.sv */
// Testbench for the retransmit window tracker: directed and random items checked by a predictor.
module tb_retransmit_window_tracker;
    import rwt_pkg::*;

    localparam int  TABLE_DEPTH = 1024;
    localparam longint CYCLE_LIMIT = 6000000;
    // Opcode that the block must ignore.
    localparam logic [1:0] OP_UNUSED = 2'd3;

    // One result item as the block should produce it.
    typedef struct packed {
        logic             send_valid;
        logic [31:0]      send_seq;
        logic             is_resend;
        logic             transfer_done;
        logic [CNT_W-1:0] pending_count;
        logic             last;
    } send_order_t;

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;
    logic [1:0]           s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic [1:0]           m_tuser;
    logic                 m_tlast;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [1:0]           cfg_index;
    logic [31:0]          cfg_data;

    int     tx_idle_pct;
    int     rx_idle_pct;
    longint cycle_count;
    int     items_sent;

    // Predicts the send orders of the tracker and compares them with what comes out.
    class send_scoreboard;
        logic [31:0]  chunk_count;
        logic [15:0]  resend_timeout;
        logic [5:0]   send_budget;
        logic [31:0]  next_seq;
        logic [31:0]  pend_seq[$];
        logic [31:0]  pend_stamp[$];
        send_order_t  due_orders[$];
        int           errors;
        int           results_seen;
        int           resends_seen;

        function void reset_state();
            chunk_count    = CHUNK_COUNT_RST;
            resend_timeout = RESEND_TIMEOUT_RST;
            send_budget    = SEND_BUDGET_RST;
            next_seq       = 0;
            pend_seq.delete();
            pend_stamp.delete();
        endfunction

        function void set_reg(logic [1:0] idx, logic [31:0] val);
            case (idx)
                CFG_CHUNK_COUNT:    chunk_count    = val;
                CFG_RESEND_TIMEOUT: resend_timeout = val[15:0];
                CFG_SEND_BUDGET:    send_budget    = val[5:0];
                default: ;
            endcase
        endfunction

        // Works out the send orders that one accepted item causes.
        function void note_input(logic [1:0] op, logic [31:0] now, logic [255:0] acks);
            logic [31:0] seqs[$];
            logic        kinds[$];
            logic [31:0] age;
            logic [31:0] want;
            logic        all_issued;
            logic        done;
            int          sent;
            send_order_t o;
            sent = 0;
            if (op == OP_TICK) begin
                // Once every chunk has gone out, every pending entry is due.
                all_issued = (next_seq >= chunk_count);
                for (int i = 0; i < pend_seq.size() && sent < send_budget; i++) begin
                    age = now - pend_stamp[i];
                    if (all_issued || age > {16'd0, resend_timeout}) begin
                        pend_stamp[i] = now;
                        seqs.push_back(pend_seq[i]);
                        kinds.push_back(1'b1);
                        sent++;
                    end
                end
                while (sent < send_budget && next_seq < chunk_count &&
                       pend_seq.size() < TABLE_DEPTH) begin
                    pend_seq.push_back(next_seq);
                    pend_stamp.push_back(now);
                    seqs.push_back(next_seq);
                    kinds.push_back(1'b0);
                    sent++;
                    next_seq++;
                end
            end else if (op == OP_ACK) begin
                // Each ack field removes at most the first matching entry.
                for (int a = 0; a < ACK_FIELDS; a++) begin
                    want = acks[32*a +: 32];
                    for (int i = 0; i < pend_seq.size(); i++) begin
                        if (pend_seq[i] == want) begin
                            pend_seq.delete(i);
                            pend_stamp.delete(i);
                            break;
                        end
                    end
                end
            end else if (op == OP_START) begin
                pend_seq.delete();
                pend_stamp.delete();
                next_seq = 0;
            end
            done = (next_seq >= chunk_count) && (pend_seq.size() == 0);
            if (sent == 0) begin
                o = '0;
                o.transfer_done = done;
                o.pending_count = CNT_W'(pend_seq.size());
                o.last          = 1'b1;
                due_orders.push_back(o);
            end
            for (int k = 0; k < sent; k++) begin
                o.send_valid    = 1'b1;
                o.send_seq      = seqs[k];
                o.is_resend     = kinds[k];
                o.transfer_done = done;
                o.pending_count = CNT_W'(pend_seq.size());
                o.last          = (k == sent - 1);
                due_orders.push_back(o);
            end
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            $display("mismatch at result %0d: %s got %0h expected %0h",
                     results_seen, what, got, want);
        endtask

        task check_result(send_order_t got);
            send_order_t want;
            results_seen++;
            if (due_orders.size() == 0) begin
                report("unexpected result, send_seq", 64'(got.send_seq), '0);
            end else begin
                want = due_orders.pop_front();
                if (got.send_valid !== want.send_valid)
                    report("send_valid", 64'(got.send_valid), 64'(want.send_valid));
                if (got.send_seq !== want.send_seq)
                    report("send_seq", 64'(got.send_seq), 64'(want.send_seq));
                if (got.is_resend !== want.is_resend)
                    report("is_resend", 64'(got.is_resend), 64'(want.is_resend));
                if (got.transfer_done !== want.transfer_done)
                    report("transfer_done", 64'(got.transfer_done), 64'(want.transfer_done));
                if (got.pending_count !== want.pending_count)
                    report("pending_count", 64'(got.pending_count), 64'(want.pending_count));
                if (got.last !== want.last)
                    report("last", 64'(got.last), 64'(want.last));
                if (want.is_resend)
                    resends_seen++;
            end
        endtask
    endclass

    send_scoreboard sb;

    retransmit_window_tracker i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // Cycle counter that ends a hung run.
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_retransmit_window_tracker: done, errors");
            $finish;
        end
    end

    // The receiver stalls at random; the rate follows the current phase.
    always @(negedge aclk) begin
        if (aresetn)
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    // Every accepted result item is unpacked and checked against the oldest expectation.
    always @(posedge aclk) begin
        send_order_t got;
        if (aresetn && m_tvalid && m_tready) begin
            got.send_valid    = m_tuser[0];
            got.is_resend     = m_tuser[1];
            got.send_seq      = m_tdata[31:0];
            got.transfer_done = m_tdata[32];
            got.pending_count = m_tdata[43:33];
            got.last          = m_tlast;
            sb.check_result(got);
        end
    end

    // Waits for every expected result, then lets a few more cycles pass.
    task wait_drain();
        while (sb.due_orders.size() != 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
        @(negedge aclk);
    endtask

    task write_reg(logic [1:0] idx, logic [31:0] val);
        wait_drain();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = val;
        do @(posedge aclk); while (!cfg_ready);
        sb.set_reg(idx, val);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task set_all(logic [31:0] chunks, logic [15:0] tmo, logic [5:0] budget);
        write_reg(CFG_CHUNK_COUNT, chunks);
        write_reg(CFG_RESEND_TIMEOUT, {16'd0, tmo});
        write_reg(CFG_SEND_BUDGET, {26'd0, budget});
    endtask

    // Offers one item, with random idle cycles in front of it, and holds it until taken.
    task push_item(logic [1:0] op, logic [31:0] now, logic [255:0] acks);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid = 1'b0;
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser  = op;
        s_tdata  = {acks, now};
        do @(posedge aclk); while (!s_tready);
        sb.note_input(op, now, acks);
        items_sent++;
        @(negedge aclk);
        s_tvalid = 1'b0;
    endtask

    // Builds an ack item that mostly names pending sequences, with strays mixed in.
    function logic [255:0] pick_acks();
        logic [255:0] acks;
        for (int a = 0; a < ACK_FIELDS; a++) begin
            if (sb.pend_seq.size() != 0 && $urandom_range(99) < 75)
                acks[32*a +: 32] = sb.pend_seq[$urandom_range(sb.pend_seq.size() - 1)];
            else
                acks[32*a +: 32] = $urandom;
        end
        return acks;
    endfunction

    task run_phase(int n_items, logic [31:0] chunks, logic [15:0] tmo, logic [5:0] budget);
        logic [31:0] clock_ms;
        int          roll;
        set_all(chunks, tmo, budget);
        clock_ms = $urandom;
        push_item(OP_START, clock_ms, '0);
        for (int n = 0; n < n_items; n++) begin
            // Halfway through, the sender holds off until the block has caught up.
            if (n == n_items / 2)
                wait_drain();
            roll = $urandom_range(99);
            if (roll < 60) begin
                clock_ms += $urandom_range(0, 2 * tmo + 2);
                push_item(OP_TICK, clock_ms, 256'($urandom));
            end else if (roll < 92) begin
                push_item(OP_ACK, clock_ms, pick_acks());
            end else if (roll < 95) begin
                push_item(OP_UNUSED, $urandom, {$urandom, $urandom, $urandom, $urandom,
                                                $urandom, $urandom, $urandom, $urandom});
            end else if (roll < 97) begin
                push_item(OP_START, clock_ms, '0);
            end else begin
                push_item(OP_TICK, $urandom, '0);
            end
        end
    endtask

    initial begin
        sb = new();
        sb.reset_state();
        cycle_count = 0;
        items_sent  = 0;
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        s_tuser     = OP_TICK;
        m_tready    = 1'b0;
        cfg_valid   = 1'b0;
        cfg_index   = CFG_CHUNK_COUNT;
        cfg_data    = '0;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Empty transfer straight out of reset: done at once, plus the idle codes.
        push_item(OP_TICK, 32'd0, '0);
        push_item(OP_ACK, 32'hFFFF_FFFF, {8{32'hFFFF_FFFF}});
        push_item(OP_UNUSED, 32'hFFFF_FFFF, {8{32'hA5A5_5A5A}});
        push_item(OP_START, 32'd0, '0);

        // Small transfer: budget limits, timeout edge, time wrap and the all-issued resend.
        set_all(32'd5, 16'd10, 6'd2);
        push_item(OP_TICK, 32'd0, '0);
        push_item(OP_TICK, 32'd10, '0);
        push_item(OP_TICK, 32'd11, '0);
        push_item(OP_ACK, 32'd11, {32'd9, 32'd9, 32'd7, 32'd7, 32'd3, 32'd1, 32'd1, 32'd1});
        push_item(OP_TICK, 32'hFFFF_FFF0, '0);
        push_item(OP_TICK, 32'h0000_0005, '0);
        push_item(OP_TICK, 32'h0000_0006, '0);
        push_item(OP_ACK, 32'd6, {32'd0, 32'd2, 32'd4, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0});
        push_item(OP_TICK, 32'd7, '0);

        // Degenerate budget and timeout.
        set_all(32'd8, 16'd0, 6'd0);
        push_item(OP_TICK, 32'd100, '0);
        write_reg(CFG_SEND_BUDGET, 32'd63);
        push_item(OP_TICK, 32'd100, '0);
        push_item(OP_TICK, 32'd100, '0);
        push_item(OP_TICK, 32'd101, '0);
        push_item(OP_START, 32'd0, '0);

        // Fill the table to the top with the largest transfer, then resend from a full table.
        set_all(32'hFFFF_FFFF, 16'hFFFF, 6'd63);
        for (int t = 0; t < 17; t++)
            push_item(OP_TICK, 32'd1000, '0);
        push_item(OP_TICK, 32'd1000 + 32'h0001_0000, '0);
        push_item(OP_ACK, 32'd0, {32'd1023, 32'd512, 32'd0, 32'd5, 32'd5, 32'd700,
                                  32'd1, 32'd1});
        push_item(OP_TICK, 32'hFFFF_FFFF, '0);
        push_item(OP_START, 32'd0, '0);

        // Random part in three idling phases.
        tx_idle_pct = 21;
        rx_idle_pct = 87;
        run_phase(90, $urandom_range(20, 300), 16'($urandom_range(1, 3000)), 6'd1);
        tx_idle_pct = 87;
        rx_idle_pct = 21;
        run_phase(90, $urandom_range(20, 300), 16'($urandom_range(1, 3000)), 6'd63);
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_phase(90, $urandom_range(20, 300), 16'($urandom_range(1, 3000)),
                  6'($urandom_range(1, 63)));

        wait_drain();
        repeat (200) @(posedge aclk);
        if (sb.due_orders.size() != 0) begin
            sb.errors++;
            $display("%0d expected results never arrived", sb.due_orders.size());
        end
        $display("covered %0d items and %0d results, %0d of them resends, in %0d cycles",
                 items_sent, sb.results_seen, sb.resends_seen, cycle_count);
        if (sb.errors == 0) begin
            $display("tb_retransmit_window_tracker: done, clean");
        end else begin
            $display("tb_retransmit_window_tracker: done, errors");
        end
        $finish;
    end
endmodule

/* files.f */
+incdir+src
src/rwt_pkg.sv
src/rwt_ack_cell.sv
src/retransmit_window_tracker.sv
bench/tb_retransmit_window_tracker.sv
